// File: rtl/acsi_pkg.sv
// acsi_pkg: shared constants, types and helper functions for the csi parser
// used by acsi_front, acsi_queue, acsi_back and ansi_csi_escape_parser_unit
package acsi_pkg;

	localparam int ARG_SLOTS_DEF = 8;
	localparam int MAX_RESULTS   = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 9;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;
	localparam logic [8:0] SCREEN_WIDTH_RST  = 9'd80;
	localparam logic [8:0] SCREEN_HEIGHT_RST = 9'd25;

	localparam logic [15:0] VALUE_MAX = 16'hFFFF;

	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_SGR      = 8'h6D;
	localparam logic [7:0] CH_UP       = 8'h41;
	localparam logic [7:0] CH_DOWN     = 8'h42;
	localparam logic [7:0] CH_RIGHT    = 8'h43;
	localparam logic [7:0] CH_LEFT     = 8'h44;
	localparam logic [7:0] CH_HOME     = 8'h48;
	localparam logic [7:0] CH_HOME_F   = 8'h66;
	localparam logic [7:0] CH_ERASE    = 8'h4A;

	localparam logic [15:0] SGR_BRIGHT_FG = 16'd1;
	localparam logic [15:0] SGR_BRIGHT_BG = 16'd21;
	localparam logic [15:0] SGR_FG_LO     = 16'd30;
	localparam logic [15:0] SGR_FG_HI     = 16'd37;
	localparam logic [15:0] SGR_BG_LO     = 16'd40;
	localparam logic [15:0] SGR_BG_HI     = 16'd47;
	localparam logic [15:0] ERASE_ALL     = 16'd2;
	localparam logic [3:0]  FG_DEFAULT    = 4'd7;
	localparam logic [3:0]  BG_DEFAULT    = 4'd0;

	localparam logic [2:0] KIND_PRINT = 3'd0;
	localparam logic [2:0] KIND_FG    = 3'd1;
	localparam logic [2:0] KIND_BG    = 3'd2;
	localparam logic [2:0] KIND_MOVE  = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	localparam logic [2:0] CMD_PRINT = 3'd0;
	localparam logic [2:0] CMD_SGR   = 3'd1;
	localparam logic [2:0] CMD_UP    = 3'd2;
	localparam logic [2:0] CMD_DOWN  = 3'd3;
	localparam logic [2:0] CMD_RIGHT = 3'd4;
	localparam logic [2:0] CMD_LEFT  = 3'd5;
	localparam logic [2:0] CMD_HOME  = 3'd6;
	localparam logic [2:0] CMD_CLEAR = 3'd7;

	localparam logic [2:0] CLS_NONE      = 3'd0;
	localparam logic [2:0] CLS_RESET     = 3'd1;
	localparam logic [2:0] CLS_FG_BRIGHT = 3'd2;
	localparam logic [2:0] CLS_BG_BRIGHT = 3'd3;
	localparam logic [2:0] CLS_FG        = 3'd4;
	localparam logic [2:0] CLS_BG        = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] color;
	} sgr_arg_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  ch;
		logic [7:0]  cx;
		logic [7:0]  cy;
		logic [15:0] n0;
		logic [15:0] n1;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic [3:0] color;
		logic [7:0] x;
		logic [7:0] y;
		logic       last;
	} res_t;

	function automatic sgr_arg_t sgr_classify(logic empty, logic [15:0] v);
		sgr_arg_t r;
		logic [15:0] d30;
		logic [15:0] d40;
		begin
			r.op = CLS_NONE;
			r.color = 3'd0;
			d30 = v - SGR_FG_LO;
			d40 = v - SGR_BG_LO;
			if (empty || v == 16'd0) begin
				r.op = CLS_RESET;
			end else if (v == SGR_BRIGHT_FG) begin
				r.op = CLS_FG_BRIGHT;
			end else if (v == SGR_BRIGHT_BG) begin
				r.op = CLS_BG_BRIGHT;
			end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
				r.op = CLS_FG;
				r.color = d30[2:0];
			end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
				r.op = CLS_BG;
				r.color = d40[2:0];
			end
			return r;
		end
	endfunction

	function automatic logic [15:0] count_arg(logic empty, logic [15:0] v);
		return (empty || v == 16'd0) ? 16'd1 : v;
	endfunction

	// last valid coordinate for a size register
	function automatic logic [7:0] size_limit(logic [8:0] s);
		logic [8:0] m;
		begin
			m = s - 9'd1;
			if (s == 9'd0) begin
				return 8'd0;
			end else if (s > 9'd256) begin
				return 8'd255;
			end
			return m[7:0];
		end
	endfunction

endpackage

// File: rtl/ansi_csi_escape_parser_unit.sv
// ansi_csi_escape_parser_unit: top level of the csi escape parser
// depends on acsi_pkg, acsi_front, acsi_queue and acsi_back
//
// input channel: one console byte per beat with the display's cursor
// (in_valid/in_ready). output channel: display commands (out_valid/out_ready),
// last marks the final command caused by one byte; bytes that cause nothing
// give no output beat.
// config: cfg_we/cfg_index/cfg_data write screen_width (0) and screen_height (1)
// a byte's first command passes the command queue, then the result register.
// throughput: one byte per cycle into a 2-entry command queue while in_ready
// is high; print, move and clear commands leave at one per cycle while the
// receiver takes them. an sgr final byte holds the back end while it walks its
// arguments (an emitting reset gives fg and bg), so the sgr walk sets the rate.
// reset: parser waits for escape, bright flags clear, screen is 80 x 25.
// when the receiver stalls the result register holds, the queue fills and
// in_ready drops once both entries are taken.
module ansi_csi_escape_parser_unit import acsi_pkg::*; #(
	parameter int ARG_SLOTS = ARG_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic [7:0]            cur_x,
	input  logic [7:0]            cur_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            kind,
	output logic [7:0]            out_char,
	output logic [3:0]            color_index,
	output logic [7:0]            new_x,
	output logic [7:0]            new_y,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W  = $clog2(ARG_SLOTS + 1);
	localparam int ARGS_W = ARG_SLOTS * $bits(sgr_arg_t);
	localparam int DATA_W = $bits(cmd_t) + ARGS_W + CNT_W;

	logic [8:0]               screen_width_q;
	logic [8:0]               screen_height_q;

	logic                     push;
	logic                     push_ready;
	cmd_t                     push_cmd;
	sgr_arg_t [ARG_SLOTS-1:0] push_args;
	logic [CNT_W-1:0]         push_cnt;
	logic                     q_valid;
	logic                     q_pop;
	logic [DATA_W-1:0]        q_data;
	cmd_t                     q_cmd;
	sgr_arg_t [ARG_SLOTS-1:0] q_args;
	logic [CNT_W-1:0]         q_cnt;
	res_t                     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	acsi_front #(.ARG_SLOTS(ARG_SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.cur_x     (cur_x),
		.cur_y     (cur_y),
		.push      (push),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.push_args (push_args),
		.push_cnt  (push_cnt)
	);

	acsi_queue #(.DATA_W(DATA_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_data ({push_cmd, push_args, push_cnt}),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_data)
	);

	assign {q_cmd, q_args, q_cnt} = q_data;

	acsi_back #(.ARG_SLOTS(ARG_SLOTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd),
		.q_args   (q_args),
		.q_cnt    (q_cnt),
		.w_lim    (size_limit(screen_width_q)),
		.h_lim    (size_limit(screen_height_q)),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (res)
	);

	assign kind = res.kind;
	assign out_char = res.ch;
	assign color_index = res.color;
	assign new_x = res.x;
	assign new_y = res.y;
	assign last = res.last;

endmodule

// File: rtl/acsi_front.sv
// acsi_front: byte parser, collects csi arguments and classifies sgr args
// depends on acsi_pkg; feeds command beats to acsi_queue
module acsi_front import acsi_pkg::*; #(
	parameter int ARG_SLOTS = ARG_SLOTS_DEF,
	localparam int CNT_W = $clog2(ARG_SLOTS + 1),
	localparam int IDX_W = $clog2(ARG_SLOTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               in_byte,
	input  logic [7:0]               cur_x,
	input  logic [7:0]               cur_y,
	output logic                     push,
	input  logic                     push_ready,
	output cmd_t                     push_cmd,
	output sgr_arg_t [ARG_SLOTS-1:0] push_args,
	output logic [CNT_W-1:0]         push_cnt
);

	localparam logic [1:0] PH_WAIT    = 2'd0;
	localparam logic [1:0] PH_BRACKET = 2'd1;
	localparam logic [1:0] PH_ARGS    = 2'd2;

	logic [1:0]               phase_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [15:0]              acc_q;
	logic                     acc_empty_q;
	logic [15:0]              s0_q;
	logic                     s0_empty_q;
	logic [15:0]              s1_q;
	logic                     s1_empty_q;
	sgr_arg_t [ARG_SLOTS-1:0] cls_q;

	logic                     accept;
	logic                     is_digit;
	logic [7:0]               digit;
	logic [19:0]              acc_wide;
	logic [15:0]              acc_next;
	logic                     k_slot;
	logic [CNT_W-1:0]         cnt_inc;
	logic                     e0_empty;
	logic [15:0]              e0_val;
	logic                     e1_empty;
	logic [15:0]              e1_val;
	sgr_arg_t [ARG_SLOTS-1:0] args_d;

	assign in_ready = push_ready;

	always_comb begin
		accept = in_valid && push_ready;
		is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		digit = in_byte - CH_ZERO;
		acc_wide = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {16'd0, digit[3:0]};
		acc_next = (acc_wide > {4'd0, VALUE_MAX}) ? VALUE_MAX : acc_wide[15:0];
		k_slot = cnt_q < CNT_W'(ARG_SLOTS);
		cnt_inc = k_slot ? cnt_q + CNT_W'(1) : cnt_q;
		args_d = cls_q;
		if (k_slot) begin
			args_d[cnt_q[IDX_W-1:0]] = sgr_classify(acc_empty_q, acc_q);
		end
		e0_empty = (cnt_q == '0) ? acc_empty_q : s0_empty_q;
		e0_val = (cnt_q == '0) ? acc_q : s0_q;
		e1_empty = (cnt_q == CNT_W'(1)) ? acc_empty_q : s1_empty_q;
		e1_val = (cnt_q == CNT_W'(1)) ? acc_q : s1_q;

		push_cmd.cmd = CMD_PRINT;
		push_cmd.ch = in_byte;
		push_cmd.cx = cur_x;
		push_cmd.cy = cur_y;
		push_cmd.n0 = count_arg(e0_empty, e0_val);
		push_cmd.n1 = count_arg(e1_empty, e1_val);
		push_args = args_d;
		push_cnt = cnt_inc;
		push = 1'b0;
		case (phase_q)
			PH_WAIT: begin
				push = accept && (in_byte != CH_ESC);
			end
			PH_BRACKET: begin
				push = accept && (in_byte != CH_LBRACKET);
			end
			PH_ARGS: begin
				if (!is_digit && in_byte != CH_SEMI) begin
					case (in_byte)
						CH_SGR: begin
							push_cmd.cmd = CMD_SGR;
							push = accept;
						end
						CH_UP: begin
							push_cmd.cmd = CMD_UP;
							push = accept;
						end
						CH_DOWN: begin
							push_cmd.cmd = CMD_DOWN;
							push = accept;
						end
						CH_RIGHT: begin
							push_cmd.cmd = CMD_RIGHT;
							push = accept;
						end
						CH_LEFT: begin
							push_cmd.cmd = CMD_LEFT;
							push = accept;
						end
						CH_HOME, CH_HOME_F: begin
							push_cmd.cmd = CMD_HOME;
							push = accept;
						end
						CH_ERASE: begin
							push_cmd.cmd = CMD_CLEAR;
							push = accept && !e0_empty && (e0_val == ERASE_ALL);
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cnt_q <= '0;
			acc_empty_q <= 1'b1;
			s0_empty_q <= 1'b1;
			s1_empty_q <= 1'b1;
		end else if (accept) begin
			case (phase_q)
				PH_WAIT: begin
					if (in_byte == CH_ESC) begin
						phase_q <= PH_BRACKET;
						cnt_q <= '0;
						acc_empty_q <= 1'b1;
						s0_empty_q <= 1'b1;
						s1_empty_q <= 1'b1;
					end
				end
				PH_BRACKET: begin
					phase_q <= (in_byte == CH_LBRACKET) ? PH_ARGS : PH_WAIT;
				end
				PH_ARGS: begin
					if (is_digit) begin
						acc_empty_q <= 1'b0;
					end else begin
						cnt_q <= cnt_inc;
						acc_empty_q <= 1'b1;
						if (cnt_q == '0) begin
							s0_empty_q <= acc_empty_q;
						end
						if (cnt_q == CNT_W'(1)) begin
							s1_empty_q <= acc_empty_q;
						end
						if (in_byte != CH_SEMI) begin
							phase_q <= PH_WAIT;
						end
					end
				end
				default: phase_q <= PH_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (phase_q == PH_WAIT && in_byte == CH_ESC) begin
				acc_q <= 16'd0;
			end else if (phase_q == PH_ARGS) begin
				if (is_digit) begin
					acc_q <= acc_next;
				end else begin
					acc_q <= 16'd0;
					cls_q <= args_d;
					if (cnt_q == '0) begin
						s0_q <= acc_q;
					end
					if (cnt_q == CNT_W'(1)) begin
						s1_q <= acc_q;
					end
				end
			end
		end
	end

endmodule

// File: rtl/acsi_queue.sv
// acsi_queue: short command queue between parser front and executing back
// depends on acsi_pkg for the queue depth
module acsi_queue import acsi_pkg::*; #(
	parameter int DATA_W = 8,
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data
);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> pop_valid)
		else $error("queue empty right after a push");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count past depth");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> push_ready)
		else $error("queue still full right after a pop");

endmodule

// File: rtl/acsi_back.sv
// acsi_back: executes queued commands, walks sgr arguments, owns bright flags
// depends on acsi_pkg; drives the registered result channel
module acsi_back import acsi_pkg::*; #(
	parameter int ARG_SLOTS = ARG_SLOTS_DEF,
	localparam int CNT_W = $clog2(ARG_SLOTS + 1),
	localparam int IDX_W = $clog2(ARG_SLOTS),
	localparam int RES_W = $clog2(MAX_RESULTS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	output logic                     q_pop,
	input  cmd_t                     q_cmd,
	input  sgr_arg_t [ARG_SLOTS-1:0] q_args,
	input  logic [CNT_W-1:0]         q_cnt,
	input  logic [7:0]               w_lim,
	input  logic [7:0]               h_lim,
	output logic                     out_valid,
	input  logic                     out_ready,
	output res_t                     out_res
);

	logic [IDX_W-1:0] idx_q;
	logic             sub_q;
	logic [RES_W-1:0] nres_q;
	logic             fg_bright_q;
	logic             bg_bright_q;
	logic             out_valid_q;
	res_t             res_q;

	sgr_arg_t         arg;
	logic             is_sgr;
	logic             room;
	logic             step;
	logic             arg_emits;
	logic             arg_done;
	logic             last_arg;
	logic             later;
	logic             emit_now;
	logic             pop_now;
	logic [16:0]      sum_y;
	logic [16:0]      sum_x;
	logic [15:0]      home_y;
	logic [15:0]      home_x;
	res_t             res_d;

	always_comb begin
		arg = q_args[idx_q];
		is_sgr = q_cmd.cmd == CMD_SGR;
		room = nres_q < RES_W'(MAX_RESULTS);
		step = q_valid && (!out_valid_q || out_ready);
		arg_emits = (arg.op == CLS_RESET) || (arg.op == CLS_FG) || (arg.op == CLS_BG);
		arg_done = !(arg.op == CLS_RESET && !sub_q && room);
		last_arg = (CNT_W'(idx_q) + CNT_W'(1)) == q_cnt;
		later = (arg.op == CLS_RESET) && !sub_q;
		for (int j = 0; j < ARG_SLOTS; j++) begin
			if (j > int'(idx_q) && j < int'(q_cnt) &&
			    (q_args[j].op == CLS_RESET || q_args[j].op == CLS_FG ||
			     q_args[j].op == CLS_BG)) begin
				later = 1'b1;
			end
		end
		emit_now = is_sgr ? (room && arg_emits) : 1'b1;
		pop_now = is_sgr ? (arg_done && last_arg) : 1'b1;
		q_pop = step && pop_now;

		sum_y = {9'd0, q_cmd.cy} + {1'b0, q_cmd.n0};
		sum_x = {9'd0, q_cmd.cx} + {1'b0, q_cmd.n0};
		home_y = q_cmd.n0 - 16'd1;
		home_x = q_cmd.n1 - 16'd1;

		res_d.kind = KIND_PRINT;
		res_d.ch = 8'd0;
		res_d.color = 4'd0;
		res_d.x = 8'd0;
		res_d.y = 8'd0;
		res_d.last = 1'b1;
		case (q_cmd.cmd)
			CMD_PRINT: begin
				res_d.ch = q_cmd.ch;
			end
			CMD_SGR: begin
				res_d.last = !later || (nres_q == RES_W'(MAX_RESULTS - 1));
				case (arg.op)
					CLS_RESET: begin
						res_d.kind = sub_q ? KIND_BG : KIND_FG;
						res_d.color = sub_q ? BG_DEFAULT : FG_DEFAULT;
					end
					CLS_FG: begin
						res_d.kind = KIND_FG;
						res_d.color = {fg_bright_q, arg.color};
					end
					CLS_BG: begin
						res_d.kind = KIND_BG;
						res_d.color = {bg_bright_q, arg.color};
					end
					default: ;
				endcase
			end
			CMD_UP: begin
				res_d.kind = KIND_MOVE;
				res_d.x = q_cmd.cx;
				res_d.y = ({8'd0, q_cmd.cy} >= q_cmd.n0) ? q_cmd.cy - q_cmd.n0[7:0] : 8'd0;
			end
			CMD_DOWN: begin
				res_d.kind = KIND_MOVE;
				res_d.x = q_cmd.cx;
				res_d.y = (sum_y > {9'd0, h_lim}) ? h_lim : sum_y[7:0];
			end
			CMD_RIGHT: begin
				res_d.kind = KIND_MOVE;
				res_d.y = q_cmd.cy;
				res_d.x = (sum_x > {9'd0, w_lim}) ? w_lim : sum_x[7:0];
			end
			CMD_LEFT: begin
				res_d.kind = KIND_MOVE;
				res_d.y = q_cmd.cy;
				res_d.x = ({8'd0, q_cmd.cx} >= q_cmd.n0) ? q_cmd.cx - q_cmd.n0[7:0] : 8'd0;
			end
			CMD_HOME: begin
				res_d.kind = KIND_MOVE;
				res_d.y = (home_y > {8'd0, h_lim}) ? h_lim : home_y[7:0];
				res_d.x = (home_x > {8'd0, w_lim}) ? w_lim : home_x[7:0];
			end
			CMD_CLEAR: begin
				res_d.kind = KIND_CLEAR;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sub_q <= 1'b0;
			nres_q <= '0;
			fg_bright_q <= 1'b0;
			bg_bright_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step && emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step && is_sgr) begin
				if (pop_now) begin
					nres_q <= '0;
				end else if (emit_now) begin
					nres_q <= nres_q + RES_W'(1);
				end
				if (arg_done) begin
					idx_q <= last_arg ? '0 : idx_q + IDX_W'(1);
					sub_q <= 1'b0;
				end else begin
					sub_q <= 1'b1;
				end
				case (arg.op)
					CLS_FG_BRIGHT: fg_bright_q <= 1'b1;
					CLS_BG_BRIGHT: bg_bright_q <= 1'b1;
					CLS_RESET: begin
						if (arg_done) begin
							fg_bright_q <= 1'b0;
							bg_bright_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit_now) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = res_q;

	a_nres_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= RES_W'(MAX_RESULTS))
		else $error("result count past limit");

	a_sub_on_reset: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> q_valid && is_sgr && arg.op == CLS_RESET)
		else $error("second reset beat without a reset argument");

	a_walk_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && is_sgr |=> idx_q == '0 && !sub_q && nres_q == '0)
		else $error("sgr walk state not rewound after pop");

endmodule
